// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds, consequent in the next cycle
`define SEL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// antecedent holds, consequent in the same cycle
`define SEL_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

// ===== src/sel_pkg.sv =====
`default_nettype none
package sel_pkg;

    localparam int COORD_W = 32;
    localparam int FRAC_W  = 16;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int ACC_W   = PROD_W;
    localparam int LEN_W   = ACC_W / 2;
    localparam int REST_W  = 31;
    localparam int THR_W   = 16;
    localparam int RATIO_W = 32;
    localparam int CNT_W   = 6;

    localparam logic [1:0] CFG_TOLERANCE   = 2'd0;
    localparam logic [1:0] CFG_ALLOW_COMPR = 2'd1;
    localparam logic [1:0] CFG_SMALL_THR   = 2'd2;

    localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(1) << FRAC_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ,
        ST_SQRT,
        ST_DIV,
        ST_RATIO,
        ST_SCALE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic       load;
        logic       mul_en;
        logic       mul_scale;
        logic [1:0] mul_idx;
        logic       acc_en;
        logic       sqrt_step;
        logic       div_init;
        logic       div_step;
        logic       ratio_load;
        logic       scale_wr;
        logic [1:0] wr_idx;
        logic       finish;
    } t_cmd;

    typedef struct packed {
        logic need_div;
        logic out_busy;
    } t_status;

endpackage
`default_nettype wire

// ===== src/strand_edge_length_limiter.sv =====
`default_nettype none
// Strand edge length limiter, Q16.16 fixed point.
// Input stream: one strand vertex per request, root first; tuser marks the
// root vertex. Output stream: one revised vertex per input request.
// Configuration: write enable, register index and data, written while idle:
// 0 length tolerance, 1 allow compression, 2 small length threshold.
// A root vertex goes from idle straight to the done state and passes through.
// Other vertices run the shared multiplier passes for the squared length,
// 33 steps of the bit-serial square root, the radix-2 divider (only its
// initial load when no rescaling is needed), a ratio step, the scaled
// delta on the shared multiplier, plus load and output steps.
// One vertex is in flight at a time; tready is high only while idle.
// The result sits in an output register; while the receiver stalls, the
// next vertex is still accepted and computed, and waits for the register
// to free before it completes.
// Reset clears the previous original and revised vertex to zero, the
// registers to tolerance 0, compression not allowed, threshold 1.
module strand_edge_length_limiter
    import sel_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [1:0]    i_cfg_addr,
    input  wire logic [30:0]   i_cfg_wdata,
    input  wire logic          i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    // vertex_x, vertex_y, vertex_z, edge_rest_length, zero pad
    input  wire logic [127:0]  i_s_axis_tdata,
    // root_vertex
    input  wire logic          i_s_axis_tuser,
    output logic               o_m_axis_tvalid,
    input  wire logic          i_m_axis_tready,
    // revised_x, revised_y, revised_z, was_scaled, zero pad
    output logic [103:0]       o_m_axis_tdata
);

    t_cmd               cmd;
    t_status            status;
    logic [COORD_W-1:0] rx;
    logic [COORD_W-1:0] ry;
    logic [COORD_W-1:0] rz;
    logic               scaled;

    sel_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_root     (i_s_axis_tuser),
        .o_in_ready (o_s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    sel_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_vx        (i_s_axis_tdata[31:0]),
        .i_vy        (i_s_axis_tdata[63:32]),
        .i_vz        (i_s_axis_tdata[95:64]),
        .i_rest      (i_s_axis_tdata[126:96]),
        .i_root      (i_s_axis_tuser),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_rx        (rx),
        .o_ry        (ry),
        .o_rz        (rz),
        .o_scaled    (scaled)
    );

    assign o_m_axis_tdata = {7'd0, scaled, rz, ry, rx};

`include "assert_macros.svh"

    `SEL_ASSERT_NEXT(a_one_in_flight, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready)
    `SEL_ASSERT_NEXT(a_root_fast,
        i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tuser && !o_m_axis_tvalid,
        ##1 o_m_axis_tvalid)
    `SEL_ASSERT_SAME(a_root_unscaled,
        o_m_axis_tvalid && $rose(o_m_axis_tvalid) && $past(i_s_axis_tuser, 2)
        && $past(o_s_axis_tready, 2) && $past(i_s_axis_tvalid, 2),
        !o_m_axis_tdata[96])

endmodule
`default_nettype wire

// ===== src/sel_datapath.sv =====
`default_nettype none
module sel_datapath
    import sel_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_addr,
    input  wire logic [REST_W-1:0]  i_cfg_wdata,
    input  wire logic [COORD_W-1:0] i_vx,
    input  wire logic [COORD_W-1:0] i_vy,
    input  wire logic [COORD_W-1:0] i_vz,
    input  wire logic [REST_W-1:0]  i_rest,
    input  wire logic               i_root,
    input  wire t_cmd               i_cmd,
    output t_status                 o_status,
    input  wire logic               i_out_ready,
    output logic                    o_out_valid,
    output logic [COORD_W-1:0]      o_rx,
    output logic [COORD_W-1:0]      o_ry,
    output logic [COORD_W-1:0]      o_rz,
    output logic                    o_scaled
);

    logic [REST_W-1:0]  r_tol;
    logic               r_allow;
    logic [THR_W-1:0]   r_thr;

    logic [COORD_W-1:0] r_prev_org [3];
    logic [COORD_W-1:0] r_prev_rev [3];
    logic [COORD_W-1:0] r_vin [3];
    logic [DIFF_W-1:0]  r_mag [3];
    logic               r_neg [3];
    logic [COORD_W-1:0] r_res [3];
    logic [REST_W-1:0]  r_rest;
    logic               r_root;

    logic [PROD_W-1:0]  r_prod;
    logic [ACC_W-1:0]   r_acc;
    logic [LEN_W+0:0]   r_sq_rem;
    logic [LEN_W-1:0]   r_len;
    logic [LEN_W-1:0]   r_drem;
    logic [RATIO_W-1:0] r_dnum;
    logic [RATIO_W-1:0] r_quo;
    logic               r_sat;
    logic [RATIO_W-1:0] r_ratio;

    logic               r_out_valid;
    logic [COORD_W-1:0] r_out [3];
    logic               r_scaled;

    logic [COORD_W-1:0] vin [3];
    logic [DIFF_W-1:0]  diff [3];

    logic [LEN_W+2:0]   sq_rem2;
    logic [LEN_W+2:0]   sq_trial;
    logic [RATIO_W-1:0] hi_t;
    logic [REST_W-1:0]  lo_t;
    logic               stretch;
    logic               compress;
    logic               need_div;
    logic [RATIO_W-1:0] target;
    logic [LEN_W:0]     d_rem2;
    logic [DIFF_W-1:0]  mul_a;
    logic [DIFF_W-1:0]  mul_b;

    logic [PROD_W-FRAC_W-2:0] sc_mag;
    logic [PROD_W-FRAC_W:0]   sc_base;
    logic [PROD_W-FRAC_W:0]   sc_sum;
    logic [COORD_W-1:0]       sc_sat;
    logic signed [PROD_W-FRAC_W:0] sc_sum_s;

    assign vin[0] = i_vx;
    assign vin[1] = i_vy;
    assign vin[2] = i_vz;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            diff[i] = {vin[i][COORD_W-1], vin[i]} - {r_prev_org[i][COORD_W-1], r_prev_org[i]};
        end
    end

    // square root digit step
    assign sq_rem2  = {r_sq_rem, r_acc[ACC_W-1 -: 2]};
    assign sq_trial = {1'b0, r_len, 2'b01};

    // target length selection
    assign hi_t     = {1'b0, r_rest} + {1'b0, r_tol};
    assign lo_t     = r_rest - r_tol;
    assign stretch  = {1'b0, r_len} > {{(LEN_W + 1 - RATIO_W){1'b0}}, hi_t};
    assign compress = !r_allow && (r_rest > r_tol)
                      && (r_len < {{(LEN_W - REST_W){1'b0}}, lo_t});
    assign need_div = (r_len > {{(LEN_W - THR_W){1'b0}}, r_thr}) && (stretch || compress);
    assign target   = stretch ? hi_t : {1'b0, lo_t};

    assign d_rem2   = {r_drem, r_dnum[RATIO_W-1]};

    assign mul_a = r_mag[i_cmd.mul_idx];
    assign mul_b = i_cmd.mul_scale ? {{(DIFF_W - RATIO_W){1'b0}}, r_ratio}
                                   : r_mag[i_cmd.mul_idx];

    // scaled delta added to the previous revised coordinate, saturated
    assign sc_mag   = r_prod[PROD_W-2:FRAC_W];
    assign sc_base  = {{(PROD_W - FRAC_W + 1 - COORD_W){r_prev_rev[i_cmd.wr_idx][COORD_W-1]}},
                       r_prev_rev[i_cmd.wr_idx]};
    assign sc_sum   = r_neg[i_cmd.wr_idx] ? sc_base - {2'b00, sc_mag}
                                          : sc_base + {2'b00, sc_mag};
    assign sc_sum_s = signed'(sc_sum);

    always_comb begin
        if (sc_sum_s > signed'({{(PROD_W - FRAC_W + 2 - COORD_W){1'b0}},
                                {(COORD_W - 1){1'b1}}})) begin
            sc_sat = {1'b0, {(COORD_W - 1){1'b1}}};
        end else if (sc_sum_s < -signed'({{(PROD_W - FRAC_W + 1 - COORD_W){1'b0}},
                                          1'b1, {(COORD_W - 1){1'b0}}})) begin
            sc_sat = {1'b1, {(COORD_W - 1){1'b0}}};
        end else begin
            sc_sat = sc_sum[COORD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol   <= '0;
            r_allow <= 1'b0;
            r_thr   <= THR_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_TOLERANCE:   r_tol   <= i_cfg_wdata;
                CFG_ALLOW_COMPR: r_allow <= i_cfg_wdata[0];
                CFG_SMALL_THR:   r_thr   <= i_cfg_wdata[THR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int i = 0; i < 3; i++) begin
                r_vin[i] <= vin[i];
                r_neg[i] <= diff[i][DIFF_W-1];
                r_mag[i] <= diff[i][DIFF_W-1] ? DIFF_W'(0) - diff[i] : diff[i];
            end
            r_rest   <= i_rest;
            r_root   <= i_root;
            r_acc    <= '0;
            r_sq_rem <= '0;
            r_len    <= '0;
        end else if (i_cmd.acc_en) begin
            r_acc <= r_acc + r_prod;
        end else if (i_cmd.sqrt_step) begin
            r_acc <= r_acc << 2;
            if (sq_rem2 >= sq_trial) begin
                r_sq_rem <= (LEN_W + 1)'(sq_rem2 - sq_trial);
                r_len    <= {r_len[LEN_W-2:0], 1'b1};
            end else begin
                r_sq_rem <= sq_rem2[LEN_W:0];
                r_len    <= {r_len[LEN_W-2:0], 1'b0};
            end
        end
        if (i_cmd.mul_en) begin
            r_prod <= mul_a * mul_b;
        end
        if (i_cmd.div_init) begin
            r_drem <= {{(LEN_W - FRAC_W){1'b0}}, target[RATIO_W-1:FRAC_W]};
            r_dnum <= {target[FRAC_W-1:0], {(RATIO_W - FRAC_W){1'b0}}};
            r_quo  <= '0;
            r_sat  <= {{(LEN_W - FRAC_W){1'b0}}, target[RATIO_W-1:FRAC_W]} >= r_len;
        end else if (i_cmd.div_step) begin
            r_dnum <= r_dnum << 1;
            if (d_rem2 >= {1'b0, r_len}) begin
                r_drem <= LEN_W'(d_rem2 - {1'b0, r_len});
                r_quo  <= {r_quo[RATIO_W-2:0], 1'b1};
            end else begin
                r_drem <= d_rem2[LEN_W-1:0];
                r_quo  <= {r_quo[RATIO_W-2:0], 1'b0};
            end
        end
        if (i_cmd.ratio_load) begin
            r_ratio <= !need_div ? RATIO_ONE : (r_sat ? {RATIO_W{1'b1}} : r_quo);
        end
        if (i_cmd.scale_wr) begin
            r_res[i_cmd.wr_idx] <= sc_sat;
        end
        if (i_cmd.finish) begin
            for (int i = 0; i < 3; i++) begin
                r_out[i] <= r_root ? r_vin[i] : r_res[i];
            end
            r_scaled <= !r_root && (r_ratio != RATIO_ONE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_prev_org[i] <= '0;
                r_prev_rev[i] <= '0;
            end
        end else begin
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
                for (int i = 0; i < 3; i++) begin
                    r_prev_org[i] <= r_vin[i];
                    r_prev_rev[i] <= r_root ? r_vin[i] : r_res[i];
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.need_div = need_div;
    assign o_status.out_busy = r_out_valid && !i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_rx        = r_out[0];
    assign o_ry        = r_out[1];
    assign o_rz        = r_out[2];
    assign o_scaled    = r_scaled;

endmodule
`default_nettype wire

// ===== src/sel_controller.sv =====
`default_nettype none
module sel_controller
    import sel_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire logic    i_root,
    output logic         o_in_ready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    t_state             r_state;
    t_state             n_state;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   n_cnt;

    localparam logic [CNT_W-1:0] LAST_MUL  = CNT_W'(3);
    localparam logic [CNT_W-1:0] LAST_SQRT = CNT_W'(LEN_W - 1);
    localparam logic [CNT_W-1:0] LAST_DIV  = CNT_W'(RATIO_W);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            ST_IDLE: begin
                n_cnt = '0;
                if (i_in_valid) begin
                    n_state = i_root ? ST_DONE : ST_SQ;
                end
            end
            ST_SQ: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == LAST_MUL) begin
                    n_state = ST_SQRT;
                    n_cnt   = '0;
                end
            end
            ST_SQRT: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == LAST_SQRT) begin
                    n_state = ST_DIV;
                    n_cnt   = '0;
                end
            end
            ST_DIV: begin
                n_cnt = r_cnt + CNT_W'(1);
                if ((r_cnt == '0 && !i_status.need_div) || r_cnt == LAST_DIV) begin
                    n_state = ST_RATIO;
                    n_cnt   = '0;
                end
            end
            ST_RATIO: begin
                n_state = ST_SCALE;
                n_cnt   = '0;
            end
            ST_SCALE: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == LAST_MUL) begin
                    n_state = ST_DONE;
                    n_cnt   = '0;
                end
            end
            ST_DONE: begin
                if (!i_status.out_busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_SQ: begin
                o_cmd.mul_en  = r_cnt != LAST_MUL;
                o_cmd.mul_idx = r_cnt[1:0];
                o_cmd.acc_en  = r_cnt != '0;
            end
            ST_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
            end
            ST_DIV: begin
                o_cmd.div_init = r_cnt == '0;
                o_cmd.div_step = r_cnt != '0;
            end
            ST_RATIO: begin
                o_cmd.ratio_load = 1'b1;
            end
            ST_SCALE: begin
                o_cmd.mul_en    = r_cnt != LAST_MUL;
                o_cmd.mul_scale = 1'b1;
                o_cmd.mul_idx   = r_cnt[1:0];
                o_cmd.scale_wr  = r_cnt != '0;
                o_cmd.wr_idx    = r_cnt[1:0] - 2'd1;
            end
            ST_DONE: begin
                o_cmd.finish = !i_status.out_busy;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule
`default_nettype wire

// ===== dv/tb_strand_edge_length_limiter.sv =====
module tb_strand_edge_length_limiter;
    import sel_pkg::*;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               scaled;
    } revised_t;

    typedef struct {
        bit       typed;
        revised_t value;
    } typed_t;

    typedef struct {
        bit          root;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [30:0] rest;
        bit          typed;
    } row_t;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic [1:0]   i_cfg_addr = '0;
    logic [30:0]  i_cfg_wdata = '0;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    logic [127:0] i_s_axis_tdata = '0;
    logic         i_s_axis_tuser = 1'b0;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;
    logic [103:0] o_m_axis_tdata;

    strand_edge_length_limiter dut (.*);

    always #5 i_clk = ~i_clk;

    logic [30:0] tol_reg = '0;
    logic        compr_reg = 1'b0;
    logic [15:0] thr_reg = 16'd1;
    logic signed [31:0] orig_vtx [3] = '{0, 0, 0};
    logic signed [31:0] rev_vtx [3] = '{0, 0, 0};

    revised_t revised_q [$];
    typed_t   typed_q [$];
    int       err_cnt = 0;
    int       cyc_cnt = 0;
    bit       idle_on = 1'b0;
    bit       hold_req = 1'b0;
    logic signed [31:0] last_vtx [3] = '{0, 0, 0};

    function automatic revised_t revise_vertex(logic signed [31:0] vx, logic signed [31:0] vy,
                                               logic signed [31:0] vz, logic [30:0] rest,
                                               logic root);
        logic signed [31:0]  v [3];
        logic signed [127:0] d [3];
        logic signed [127:0] bs, sv;
        logic [127:0] mag [3];
        logic [127:0] sum, r, c, len, ratio, hi_t, p;
        revised_t o;
        logic signed [31:0] res [3];
        v[0] = vx; v[1] = vy; v[2] = vz;
        ratio = 128'(1) << 16;
        if (root) begin
            res = v;
        end else begin
            sum = '0;
            for (int i = 0; i < 3; i++) begin
                d[i] = v[i];
                d[i] = d[i] - orig_vtx[i];
                mag[i] = (d[i] < 0) ? -d[i] : d[i];
                sum = sum + mag[i] * mag[i];
            end
            r = '0;
            for (int b = 63; b >= 0; b--) begin
                c = r | (128'(1) << b);
                if (c * c <= sum) r = c;
            end
            len = r;
            if (len > thr_reg) begin
                hi_t = 128'(rest) + 128'(tol_reg);
                if (len > hi_t) begin
                    ratio = (hi_t << 16) / len;
                end else if (!compr_reg && rest > tol_reg && len < 128'(rest - tol_reg)) begin
                    ratio = (128'(rest - tol_reg) << 16) / len;
                end
                if (ratio > 128'hffff_ffff) ratio = 128'hffff_ffff;
            end
            for (int i = 0; i < 3; i++) begin
                p = (mag[i] * ratio) >> 16;
                if (p > (128'(1) << 62)) p = 128'(1) << 62;
                bs = rev_vtx[i];
                sv = (d[i] < 0) ? bs - $signed(p) : bs + $signed(p);
                if (sv > 128'sh7fff_ffff) sv = 128'sh7fff_ffff;
                if (sv < -128'sh8000_0000) sv = -128'sh8000_0000;
                res[i] = sv[31:0];
            end
        end
        for (int i = 0; i < 3; i++) begin
            orig_vtx[i] = v[i];
            rev_vtx[i] = res[i];
        end
        o.x = res[0]; o.y = res[1]; o.z = res[2];
        o.scaled = (ratio != (128'(1) << 16));
        return o;
    endfunction

    always @(posedge i_clk) begin
        revised_t exp_r, got;
        typed_t   t;
        cyc_cnt <= cyc_cnt + 1;
        if (o_m_axis_tvalid && i_m_axis_tready) begin
            got.x = o_m_axis_tdata[31:0];
            got.y = o_m_axis_tdata[63:32];
            got.z = o_m_axis_tdata[95:64];
            got.scaled = o_m_axis_tdata[96];
            if (revised_q.size() == 0) begin
                $error("unexpected result %h", o_m_axis_tdata);
                err_cnt++;
            end else begin
                exp_r = revised_q.pop_front();
                if (got.x !== exp_r.x) begin
                    $error("revised_x expected %h actual %h", exp_r.x, got.x); err_cnt++;
                end
                if (got.y !== exp_r.y) begin
                    $error("revised_y expected %h actual %h", exp_r.y, got.y); err_cnt++;
                end
                if (got.z !== exp_r.z) begin
                    $error("revised_z expected %h actual %h", exp_r.z, got.z); err_cnt++;
                end
                if (got.scaled !== exp_r.scaled) begin
                    $error("was_scaled expected %b actual %b", exp_r.scaled, got.scaled);
                    err_cnt++;
                end
            end
        end
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            exp_r = revise_vertex(i_s_axis_tdata[31:0], i_s_axis_tdata[63:32],
                                  i_s_axis_tdata[95:64], i_s_axis_tdata[126:96],
                                  i_s_axis_tuser);
            t = typed_q.pop_front();
            revised_q.push_back(t.typed ? t.value : exp_r);
        end
    end

    always @(posedge i_clk) begin
        if (cyc_cnt > 1500000) begin
            $display("strand_edge_length_limiter verification failed");
            $finish;
        end
    end

    // receiver side
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_m_axis_tready = 1'b0;
                repeat (400) @(negedge i_clk);
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                i_m_axis_tready = 1'b0;
                repeat ($urandom_range(0, 13)) @(negedge i_clk);
            end else begin
                i_m_axis_tready = 1'b1;
            end
        end
    end

    task automatic write_reg(logic [1:0] addr, logic [30:0] data);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_addr = addr;
        i_cfg_wdata = data;
        case (addr)
            CFG_TOLERANCE:   tol_reg = data;
            CFG_ALLOW_COMPR: compr_reg = data[0];
            CFG_SMALL_THR:   thr_reg = data[15:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic drain;
        while (revised_q.size() != 0 || typed_q.size() != 0) @(negedge i_clk);
        repeat (90) @(negedge i_clk);
    endtask

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_vertex(bit root, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                               logic [30:0] rest, bit typed);
        typed_t t;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        t.typed = typed;
        t.value.x = x; t.value.y = y; t.value.z = z; t.value.scaled = 1'b0;
        typed_q.push_back(t);
        i_s_axis_tdata = {1'b0, rest, z, y, x};
        i_s_axis_tuser = root;
        i_s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        @(negedge i_clk);
        last_vtx[0] = x; last_vtx[1] = y; last_vtx[2] = z;
    endtask

    function automatic logic [31:0] rand_coord(logic signed [31:0] base, bit near);
        logic signed [31:0] delta;
        if (!near || $urandom_range(0, 9) == 0) return $urandom;
        delta = $signed($urandom_range(0, 1 << 18)) - (1 << 17);
        return base + delta;
    endfunction

    task automatic random_phase(int n);
        int  sent, len;
        bit  root;
        logic [30:0] rest;
        sent = 0;
        while (sent < n) begin
            len = $urandom_range(2, 8);
            for (int k = 0; k < len && sent < n; k++) begin
                root = (k == 0) && ($urandom_range(0, 9) != 0);
                if ($urandom_range(0, 9) == 0) rest = 31'($urandom);
                else rest = 31'($urandom_range(0, 1 << 19));
                send_vertex(root, rand_coord(last_vtx[0], k != 0),
                            rand_coord(last_vtx[1], k != 0),
                            rand_coord(last_vtx[2], k != 0), rest, 1'b0);
                sent++;
                if (sent == n / 2 && idle_on && !compr_reg) hold_req = 1'b1;
            end
        end
        i_s_axis_tvalid = 1'b0;
    endtask

    row_t dir_rows [] = '{
        '{0, 32'h0001_0000, 32'h0, 32'h0, 31'h0001_0000, 0},
        '{1, 32'h0, 32'h0, 32'h0, 31'h0, 1},
        '{0, 32'h0003_0000, 32'h0004_0000, 32'h0, 31'h0001_0000, 0},
        '{0, 32'h0003_0000, 32'h0004_0000, 32'h1, 31'h0001_0000, 0},
        '{0, 32'h0003_0100, 32'h0004_0000, 32'h1, 31'h0001_0000, 0},
        '{1, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 31'h7fff_ffff, 1},
        '{0, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 31'h7fff_ffff, 0},
        '{0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 31'h0, 0},
        '{1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h0, 1},
        '{0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 31'h1, 0},
        '{0, 32'h0, 32'h0, 32'h0, 31'h7fff_ffff, 0},
        '{1, 32'hffff_ffff, 32'h1, 32'h0, 31'h0, 1},
        '{0, 32'hffff_ffff, 32'h1, 32'h0, 31'h5, 0},
        '{0, 32'hfffe_0000, 32'h0002_0000, 32'h0002_0000, 31'h0010_0000, 0}
    };

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        foreach (dir_rows[r])
            send_vertex(dir_rows[r].root, dir_rows[r].x, dir_rows[r].y, dir_rows[r].z,
                        dir_rows[r].rest, dir_rows[r].typed);
        i_s_axis_tvalid = 1'b0;
        drain();
        idle_on = 1'b1;
        write_reg(CFG_TOLERANCE, 31'h0000_4000);
        write_reg(CFG_SMALL_THR, 31'h0000_0100);
        random_phase(130);
        drain();
        write_reg(CFG_ALLOW_COMPR, 31'h1);
        write_reg(CFG_TOLERANCE, 31'h7fff_ffff);
        write_reg(CFG_SMALL_THR, 31'h0000_ffff);
        random_phase(110);
        drain();
        write_reg(CFG_ALLOW_COMPR, 31'h0);
        write_reg(CFG_TOLERANCE, 31'h0);
        write_reg(CFG_SMALL_THR, 31'h0);
        random_phase(130);
        drain();
        write_reg(CFG_TOLERANCE, 31'($urandom_range(0, 1 << 17)));
        write_reg(CFG_SMALL_THR, 31'($urandom_range(0, 16'hffff)));
        random_phase(130);
        drain();
        write_reg(CFG_ALLOW_COMPR, 31'h1);
        write_reg(CFG_TOLERANCE, 31'h0000_8000);
        random_phase(120);
        drain();
        idle_on = 1'b0;
        write_reg(CFG_ALLOW_COMPR, 31'h0);
        write_reg(CFG_TOLERANCE, 31'h0000_1000);
        write_reg(CFG_SMALL_THR, 31'h0000_0001);
        random_phase(120);
        drain();
        if (err_cnt == 0) begin
            $display("strand_edge_length_limiter verification clean");
        end else begin
            $display("strand_edge_length_limiter verification failed");
        end
        $finish;
    end

endmodule
